@@ rtl/core/lpkt_pkg.sv @@
// ----------------------------------------------------------------------------
// lpkt_pkg
// Shared sizes, result codes and sequencer states of the key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

   // table capacity; must be a power of two so that key mod SLOTS is a mask
   localparam int SLOTS           = 16;
   localparam int SLOT_BITS       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_BITS      = $clog2(SLOTS + 1);
   localparam int KEY_BITS        = 32;
   localparam int HANDLE_BITS     = 32;
   localparam int OP_BITS         = 1;
   localparam int STATUS_BITS     = 2;
   localparam int SLOT_FIELD_BITS = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_MISS     = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_PROBE = 1'b1
   } state_type;

endpackage

@@ rtl/core/linear_probe_key_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Open-addressing key-to-handle table with linear probing.
// ----------------------------------------------------------------------------
// One request beat is looked up (op 0) or looked up and inserted on a miss
// (op 1). Probing starts at key mod SLOTS and reads one slot per clock from a
// single compare unit while the output register can take the result; the
// request is registered first, and its response beat is loaded into the
// output register when the probe ends. While an earlier response beat sits
// stalled in the output register, the probe holds its place. A zero key, a
// lookup miss and an insert into a full table all answer status 2 with
// handle and slot zero. The request side stalls while a probe runs; a new
// request is taken as soon as the previous one has left for the output
// register, even if that response beat is still stalled. No clearing pass is
// needed after reset: per-slot valid bits mark occupancy.
// ----------------------------------------------------------------------------
module linear_probe_key_table (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lpkt_pkg::OP_BITS-1:0]         req_op,
   input  logic [31:0]                          req_key,
   input  logic [lpkt_pkg::HANDLE_BITS-1:0]     req_handle_in,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lpkt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [lpkt_pkg::HANDLE_BITS-1:0]     rsp_handle_out,
   output logic [lpkt_pkg::SLOT_FIELD_BITS-1:0] rsp_slot
);
   import lpkt_pkg::*;

   // table storage: keys and handles carry no reset, valid bits do
   logic [KEY_BITS-1:0]    keys_ff    [SLOTS];
   logic [HANDLE_BITS-1:0] handles_ff [SLOTS];
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   // sequencer
   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   pos_ff, pos_in;
   logic [SLOT_BITS-1:0]   seen_ff, seen_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [HANDLE_BITS-1:0] hin_ff, hin_in;

   // output register
   logic                       ovalid_ff, ovalid_in;
   status_type                 ostatus_ff, ostatus_in;
   logic [HANDLE_BITS-1:0]     ohandle_ff, ohandle_in;
   logic [SLOT_FIELD_BITS-1:0] oslot_ff, oslot_in;

   // probe compare unit
   logic probe_hit, probe_empty, probe_last, out_free, req_take, do_write;

   assign out_free    = !ovalid_ff || !rsp_stall;
   assign probe_empty = !valid_ff[pos_ff];
   assign probe_hit   = valid_ff[pos_ff] && (keys_ff[pos_ff] == key_ff);
   assign probe_last  = (seen_ff == SLOT_BITS'(SLOTS - 1));
   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      seen_in    = seen_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      hin_in     = hin_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      do_write   = 1'b0;
      ovalid_in  = ovalid_ff && rsp_stall;
      ostatus_in = ostatus_ff;
      ohandle_in = ohandle_ff;
      oslot_in   = oslot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_op;
               key_in   = req_key[KEY_BITS-1:0];
               hin_in   = req_handle_in;
               pos_in   = req_key[SLOT_BITS-1:0];   // key mod SLOTS
               seen_in  = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // hold the probe until the output register can take the result
            if (out_free) begin
               if (key_ff == '0) begin
                  // reserved key
                  ovalid_in  = 1'b1;
                  ostatus_in = ST_MISS;
                  ohandle_in = '0;
                  oslot_in   = '0;
                  state_in   = S_IDLE;
               end else if (probe_hit) begin
                  ovalid_in  = 1'b1;
                  ostatus_in = ST_FOUND;
                  ohandle_in = handles_ff[pos_ff];
                  oslot_in   = SLOT_FIELD_BITS'(pos_ff);
                  state_in   = S_IDLE;
               end else if (probe_empty) begin
                  ovalid_in = 1'b1;
                  state_in  = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     do_write         = 1'b1;
                     valid_in[pos_ff] = 1'b1;
                     count_in         = count_ff + 1'b1;
                     ostatus_in       = ST_INSERTED;
                     ohandle_in       = hin_ff;
                     oslot_in         = SLOT_FIELD_BITS'(pos_ff);
                  end else begin
                     ostatus_in = ST_MISS;
                     ohandle_in = '0;
                     oslot_in   = '0;
                  end
               end else if (probe_last) begin
                  // every slot seen and taken: full table or lookup miss
                  ovalid_in  = 1'b1;
                  ostatus_in = ST_MISS;
                  ohandle_in = '0;
                  oslot_in   = '0;
                  state_in   = S_IDLE;
               end else begin
                  pos_in  = pos_ff + 1'b1;   // wraps at SLOTS
                  seen_in = seen_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      seen_ff    <= seen_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      hin_ff     <= hin_in;
      ostatus_ff <= ostatus_in;
      ohandle_ff <= ohandle_in;
      oslot_ff   <= oslot_in;
      if (do_write) begin
         keys_ff[pos_ff]    <= key_ff;
         handles_ff[pos_ff] <= hin_ff;
      end
   end

   assign rsp_valid      = ovalid_ff;
   assign rsp_status     = ostatus_ff;
   assign rsp_handle_out = ohandle_ff;
   assign rsp_slot       = oslot_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // fill count tracks the occupancy bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(valid_ff)))
      else $error("entry count disagrees with occupied slots");

   // a miss answer never carries a handle or a slot
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && ostatus_ff == ST_MISS) |-> (ohandle_ff == '0 && oslot_ff == '0))
      else $error("miss response carries data");

   // an accepted request starts a probe in the next cycle
   a_take_probes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_PROBE))
      else $error("accepted request did not start probing");

   // only an insert answer adds an occupied slot
   a_grow_on_insert: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (ovalid_ff && ostatus_ff == ST_INSERTED))
      else $error("table grew without an insert response");

endmodule
